/* rtl/uda_pkg.sv */
// shared constants and types for the unsigned to decimal ascii unit
// no dependencies
`default_nettype none

package uda_pkg;

   localparam int VALUE_BITS     = 32;
   localparam int REQ_BITS       = 32;
   localparam int CHAR_BITS      = 8;
   // decimal digits of the largest VALUE_BITS wide number
   localparam int DIGITS         = ((VALUE_BITS * 1233) >> 12) + 1;
   localparam int BCD_BITS       = DIGITS * 4;
   localparam int SHIFT_CNT_BITS = $clog2(VALUE_BITS);
   localparam int DIGIT_CNT_BITS = $clog2(DIGITS);

   localparam logic [CHAR_BITS-1:0] ASCII_ZERO = 8'h30;

   typedef struct packed {
      logic                valid;
      logic [BCD_BITS-1:0] digits;
   } bcd_word_type;

endpackage

`default_nettype wire

/* rtl/unsigned_to_decimal_ascii_unit.sv */
// top level of the unsigned to decimal ascii unit: terminator register and channels
// depends on uda_pkg, uda_dabble, uda_emit
//
// channel  direction  word                              accepted when
// req      in         tdata[31:0] value                 req_tvalid & req_tready
// rsp      out        tdata[7:0] out_char, tlast last   rsp_tvalid & rsp_tready
// csr      in         data[7:0] terminator_char         csr_valid & csr_ready
//
// the converter takes one value bit per cycle and takes a new word only once it is back
// in idle after the bcd hand-off, so req_tready stays low from acceptance until then
// the serializer steps each decimal place, then the terminator, overlapping the next conversion
// reset is synchronous and clears the terminator to zero
// a stalled rsp side holds the serializer, then the converter, then req_tready
`default_nettype none

module unsigned_to_decimal_ascii_unit (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [31:0] req_tdata,   // [31:0] value
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_char
   output logic        rsp_tlast,
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [7:0]  csr_data     // [7:0] terminator_char
);
   import uda_pkg::*;

   logic [CHAR_BITS-1:0]  term_ff, term_in;
   logic                  conv_idle;
   logic                  bcd_ready;
   bcd_word_type          bcd_word;
   logic [VALUE_BITS-1:0] value;

   assign value      = VALUE_BITS'({{VALUE_BITS{1'b0}}, req_tdata});
   assign req_tready = conv_idle;
   assign csr_ready  = 1'b1;
   assign term_in    = csr_valid ? csr_data : term_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         term_ff <= '0;
      end else begin
         term_ff <= term_in;
      end
   end

   uda_dabble u_dabble (
      .clock     (clock),
      .reset     (reset),
      .load      (req_tvalid),
      .value     (value),
      .idle      (conv_idle),
      .bcd_out   (bcd_word),
      .bcd_ready (bcd_ready)
   );

   uda_emit u_emit (
      .clock       (clock),
      .reset       (reset),
      .bcd_in_word (bcd_word),
      .bcd_ready   (bcd_ready),
      .term_char   (term_ff),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast)
   );

endmodule

`default_nettype wire

/* rtl/uda_dabble.sv */
// bit serial binary to bcd converter, one input bit per cycle with add-3 correction
// depends on uda_pkg
`default_nettype none

module uda_dabble (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            load,
   input  wire  [uda_pkg::VALUE_BITS-1:0] value,
   output logic                           idle,
   output uda_pkg::bcd_word_type          bcd_out,
   input  wire                            bcd_ready
);
   import uda_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SHIFT,
      ST_DONE
   } state_type;

   state_type                 state_ff, state_in;
   logic [VALUE_BITS-1:0]     bin_ff, bin_in;
   logic [BCD_BITS-1:0]       bcd_ff, bcd_in;
   logic [SHIFT_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [BCD_BITS-1:0]       adj;

   always_comb begin
      adj = bcd_ff;
      for (int i = 0; i < DIGITS; i++) begin
         if (bcd_ff[4*i +: 4] >= 4'd5) begin
            adj[4*i +: 4] = bcd_ff[4*i +: 4] + 4'd3;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      bin_in   = bin_ff;
      bcd_in   = bcd_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (load) begin
               bin_in   = value;
               bcd_in   = '0;
               cnt_in   = '0;
               state_in = ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            bcd_in = {adj[BCD_BITS-2:0], bin_ff[VALUE_BITS-1]};
            bin_in = {bin_ff[VALUE_BITS-2:0], 1'b0};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == SHIFT_CNT_BITS'(VALUE_BITS - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (bcd_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
      cnt_ff <= cnt_in;
   end

   assign idle           = (state_ff == ST_IDLE);
   assign bcd_out.valid  = (state_ff == ST_DONE);
   assign bcd_out.digits = bcd_ff;

endmodule

`default_nettype wire

/* rtl/uda_emit.sv */
// digit serializer: skips leading zeros, emits ascii digits then the terminator
// depends on uda_pkg
`default_nettype none

module uda_emit (
   input  wire                           clock,
   input  wire                           reset,
   input  uda_pkg::bcd_word_type         bcd_in_word,
   output logic                          bcd_ready,
   input  wire  [uda_pkg::CHAR_BITS-1:0] term_char,
   output logic                          rsp_tvalid,
   input  wire                           rsp_tready,
   output logic [uda_pkg::CHAR_BITS-1:0] rsp_tdata,
   output logic                          rsp_tlast
);
   import uda_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIGIT,
      ST_TERM
   } state_type;

   state_type                 state_ff, state_in;
   logic [BCD_BITS-1:0]       bcd_ff, bcd_in;
   logic [DIGIT_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                      started_ff, started_in;
   logic                      valid_ff, valid_in;
   logic [CHAR_BITS-1:0]      char_ff, char_in;
   logic                      last_ff, last_in;

   logic       can_out;
   logic [3:0] top;
   logic       last_digit;
   logic       show;

   assign can_out    = !valid_ff || rsp_tready;
   assign top        = bcd_ff[BCD_BITS-1 -: 4];
   assign last_digit = (cnt_ff == DIGIT_CNT_BITS'(DIGITS - 1));
   assign show       = started_ff || (top != 4'd0) || last_digit;

   always_comb begin
      state_in   = state_ff;
      bcd_in     = bcd_ff;
      cnt_in     = cnt_ff;
      started_in = started_ff;
      valid_in   = valid_ff && !rsp_tready;
      char_in    = char_ff;
      last_in    = last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (bcd_in_word.valid) begin
               bcd_in     = bcd_in_word.digits;
               cnt_in     = '0;
               started_in = 1'b0;
               state_in   = ST_DIGIT;
            end
         end
         ST_DIGIT: begin
            if (!show || can_out) begin
               if (show) begin
                  valid_in   = 1'b1;
                  char_in    = ASCII_ZERO | {4'd0, top};
                  last_in    = 1'b0;
                  started_in = 1'b1;
               end
               bcd_in = {bcd_ff[BCD_BITS-5:0], 4'd0};
               cnt_in = cnt_ff + 1'b1;
               if (last_digit) begin
                  state_in = ST_TERM;
               end
            end
         end
         ST_TERM: begin
            if (can_out) begin
               valid_in = 1'b1;
               char_in  = term_char;
               last_in  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         valid_ff   <= 1'b0;
         started_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         valid_ff   <= valid_in;
         started_ff <= started_in;
      end
      bcd_ff  <= bcd_in;
      cnt_ff  <= cnt_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign bcd_ready  = (state_ff == ST_IDLE);
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = char_ff;
   assign rsp_tlast  = last_ff;

endmodule

`default_nettype wire
